>>> rtl/core/pwmsr_pkg.sv
// ----------------------------------------------------------------------------
// PWM soft ramp period setup - shared definitions
// Widths, command codes, limits and the divider request/response types.
// ----------------------------------------------------------------------------
package pwmsr_pkg;

	localparam int FILTER_SHIFT = 3;
	localparam int CLOCK_HZ     = 16000000;

	localparam int DUTY_W    = 10;
	localparam int WORD_W    = 16;
	localparam int ACT_W     = 2;
	localparam int CSEL_W    = 2;
	localparam int DIVOUT_W  = 7;

	localparam int CLK_W     = $clog2(CLOCK_HZ + 1);
	localparam int DIV_NUM_W = (CLK_W > WORD_W + DUTY_W) ? CLK_W : WORD_W + DUTY_W;
	localparam int DIV_DEN_W = WORD_W;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	localparam logic [ACT_W-1:0] ACT_ENABLE  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DISABLE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SETFREQ = 2'd2;

	localparam logic [CSEL_W-1:0] CSEL_DIV1 = 2'd1;
	localparam logic [CSEL_W-1:0] CSEL_DIV8 = 2'd2;

	localparam logic [DIVOUT_W-1:0] DIVIDER_NONE  = 7'd0;
	localparam logic [DIVOUT_W-1:0] DIVIDER_ONE   = 7'd1;
	localparam logic [DIVOUT_W-1:0] DIVIDER_EIGHT = 7'd8;

	localparam logic [DUTY_W-1:0] DUTY_MAX       = 10'd1023;
	localparam logic [WORD_W-1:0] FREQ_MIN       = 16'd50;
	localparam logic [WORD_W-1:0] FREQ_MAX       = 16'd65472;
	localparam logic [WORD_W-1:0] FREQ_DIV8_LIMIT = 16'd122;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

>>> rtl/core/pwmsr_div.sv
// ----------------------------------------------------------------------------
// PWM soft ramp period setup - serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwmsr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pwmsr_pkg::div_req_t req,
	output pwmsr_pkg::div_rsp_t rsp
);
	import pwmsr_pkg::*;

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			// shift in next dividend bit, subtract where it fits
			if (fits) begin
				rem_q <= DIV_DEN_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DIV_DEN_W-1:0];
			end
			num_q <= {num_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = num_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider busy and done together");

endmodule

>>> rtl/core/pwm_soft_ramp_period_setup_unit.sv
// ----------------------------------------------------------------------------
// PWM soft ramp period setup unit
// Duty ramp, prescaler and counter top calculation for a PWM timer.
// ----------------------------------------------------------------------------
// One request is taken at a time. Enable and disable requests pass the
// apply and done states to the result; a set-frequency request runs the
// shared serial divider twice (duty recompute against the old top, then
// the new top from the clock rate), one quotient bit per cycle, or once,
// for the new top only, when the old top is zero. A request with an
// unused action code is taken and dropped without a result. The input side
// is ready again as soon as a result has moved to the output register.
module pwm_soft_ramp_period_setup_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [pwmsr_pkg::ACT_W-1:0]      action,
	input  logic [pwmsr_pkg::DUTY_W-1:0]     target_duty,
	input  logic [pwmsr_pkg::WORD_W-1:0]     frequency,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pwmsr_pkg::WORD_W-1:0]     compare_value,
	output logic [pwmsr_pkg::WORD_W-1:0]     period_top,
	output logic [pwmsr_pkg::CSEL_W-1:0]     clock_select,
	output logic [pwmsr_pkg::DIVOUT_W-1:0]   divider_used,
	output logic                             running,
	output logic                             counter_restart
);
	import pwmsr_pkg::*;

	localparam int SUM_W = DUTY_W + FILTER_SHIFT + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DUTY_DIV,
		ST_TOP_DIV,
		ST_APPLY,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [DUTY_W-1:0]     smoothed_q;
	logic [WORD_W-1:0]     top_q;
	logic [WORD_W-1:0]     compare_q;
	logic [CSEL_W-1:0]     presc_q;
	logic                  running_q;
	logic [DUTY_W-1:0]     duty_q;
	logic [WORD_W-1:0]     freq_q;
	logic                  div8_q;
	logic [DIVOUT_W-1:0]   divout_q;

	logic                  out_valid_q;
	logic [WORD_W-1:0]     res_compare_q;
	logic [WORD_W-1:0]     res_top_q;
	logic [CSEL_W-1:0]     res_csel_q;
	logic [DIVOUT_W-1:0]   res_divout_q;
	logic                  res_running_q;

	div_req_t              div_req;
	div_rsp_t              div_rsp;

	logic                  accept;
	logic [WORD_W-1:0]     freq_clamped;
	logic [SUM_W-1:0]      d_scaled;
	logic [SUM_W-1:0]      ramp_sum;
	logic [SUM_W-1:0]      ramp_up;
	logic [SUM_W-1:0]      ramp_down;
	logic [DUTY_W-1:0]     ramp_up_duty;
	logic [DUTY_W-1:0]     ramp_down_duty;
	logic [DUTY_W-1:0]     div_duty;
	logic [DIV_NUM_W-1:0]  quot_m1;
	logic [WORD_W-1:0]     new_top;
	logic [WORD_W+DUTY_W:0] product;
	logic [WORD_W-1:0]     period_den;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (frequency < FREQ_MIN) begin
			freq_clamped = FREQ_MIN;
		end else if (frequency > FREQ_MAX) begin
			freq_clamped = FREQ_MAX;
		end else begin
			freq_clamped = frequency;
		end
	end

	assign d_scaled  = (SUM_W'(smoothed_q) << FILTER_SHIFT) - SUM_W'(smoothed_q);
	assign ramp_sum  = d_scaled + SUM_W'(target_duty);
	assign ramp_up   = (ramp_sum >> FILTER_SHIFT) + SUM_W'(smoothed_q < target_duty);
	assign ramp_down = d_scaled >> FILTER_SHIFT;

	assign ramp_up_duty   = (ramp_up > SUM_W'(DUTY_MAX)) ? DUTY_MAX : ramp_up[DUTY_W-1:0];
	assign ramp_down_duty = (ramp_down > SUM_W'(DUTY_MAX)) ? DUTY_MAX :
		ramp_down[DUTY_W-1:0];

	assign div_duty = (div_rsp.quot > DIV_NUM_W'(DUTY_MAX)) ? DUTY_MAX :
		div_rsp.quot[DUTY_W-1:0];

	assign quot_m1 = div_rsp.quot - 1'b1;

	always_comb begin
		if (div_rsp.quot == '0) begin
			new_top = '0;
		end else if (|quot_m1[DIV_NUM_W-1:WORD_W]) begin
			new_top = '1;
		end else begin
			new_top = quot_m1[WORD_W-1:0];
		end
	end

	assign period_den = div8_q ? {freq_q[WORD_W-4:0], 3'b000} : freq_q;
	assign product    = (WORD_W+DUTY_W+1)'(duty_q) * (WORD_W+DUTY_W+1)'({1'b0, top_q} + 1'b1);

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = DIV_NUM_W'({compare_q, {DUTY_W{1'b0}}});
		div_req.den   = top_q;
		if (accept && action == ACT_SETFREQ && top_q != '0) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_DUTY_DIV && (top_q == '0 || div_rsp.done)) begin
			div_req.start = 1'b1;
			div_req.num   = DIV_NUM_W'(CLOCK_HZ);
			div_req.den   = period_den;
		end
	end

	pwmsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			smoothed_q    <= '0;
			top_q         <= '0;
			compare_q     <= '0;
			presc_q       <= '0;
			running_q     <= 1'b0;
			duty_q        <= '0;
			freq_q        <= '0;
			div8_q        <= 1'b0;
			divout_q      <= '0;
			out_valid_q   <= 1'b0;
			res_compare_q <= '0;
			res_top_q     <= '0;
			res_csel_q    <= '0;
			res_divout_q  <= '0;
			res_running_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (action)
							ACT_ENABLE: begin
								duty_q     <= ramp_up_duty;
								smoothed_q <= ramp_up_duty;
								divout_q   <= DIVIDER_NONE;
								state_q    <= ST_APPLY;
							end
							ACT_DISABLE: begin
								duty_q     <= ramp_down_duty;
								smoothed_q <= ramp_down_duty;
								divout_q   <= DIVIDER_NONE;
								state_q    <= ST_APPLY;
							end
							ACT_SETFREQ: begin
								freq_q  <= freq_clamped;
								div8_q  <= freq_clamped < FREQ_DIV8_LIMIT;
								state_q <= ST_DUTY_DIV;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_DUTY_DIV: begin
					if (top_q == '0) begin
						duty_q  <= '0;
						state_q <= ST_TOP_DIV;
					end else if (div_rsp.done) begin
						duty_q  <= div_duty;
						state_q <= ST_TOP_DIV;
					end
				end
				ST_TOP_DIV: begin
					if (div_rsp.done) begin
						top_q    <= new_top;
						presc_q  <= div8_q ? CSEL_DIV8 : CSEL_DIV1;
						divout_q <= div8_q ? DIVIDER_EIGHT : DIVIDER_ONE;
						state_q  <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					compare_q <= product[WORD_W+DUTY_W-1:DUTY_W];
					running_q <= duty_q != '0;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						res_compare_q <= compare_q;
						res_top_q     <= top_q;
						res_csel_q    <= presc_q;
						res_divout_q  <= divout_q;
						res_running_q <= running_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign compare_value   = res_compare_q;
	assign period_top      = res_top_q;
	assign clock_select    = res_csel_q;
	assign divider_used    = res_divout_q;
	assign running         = res_running_q;
	assign counter_restart = 1'b1;

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside completion");

	a_divider_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_divout_q != DIVIDER_NONE) |->
		((res_divout_q == DIVIDER_EIGHT && res_csel_q == CSEL_DIV8) ||
		 (res_divout_q == DIVIDER_ONE && res_csel_q == CSEL_DIV1)))
		else $error("divider and prescaler code disagree");

	a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DUTY_DIV || state_q == ST_TOP_DIV))
		else $error("divider finished outside a divide step");

	a_div_idle_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_rsp.busy)
		else $error("divider busy while taking requests");

endmodule

>>> test/pwm_soft_ramp_period_setup_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PWM soft ramp period setup unit - testbench
// Drives enable, disable and set-frequency requests through the valid/ready
// handshakes under varying idle and stall patterns. A scoreboard tracks the
// duty ramp, prescaler, counter top and compare threshold, and checks every
// returned timer setting field by field.
// ----------------------------------------------------------------------------
module pwm_soft_ramp_period_setup_unit_tb;
	import pwmsr_pkg::*;

	localparam int CYCLE_LIMIT    = 300000;
	localparam int TAIL_CYCLES    = 200;
	localparam int PHASE_REQUESTS = 100;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [WORD_W-1:0]   compare_value;
		logic [WORD_W-1:0]   period_top;
		logic [CSEL_W-1:0]   clock_select;
		logic [DIVOUT_W-1:0] divider_used;
		logic                running;
		logic                counter_restart;
	} timer_setting_t;

	class timer_setting_tracker;
		logic [DUTY_W-1:0] smoothed;
		logic [WORD_W-1:0] top;
		logic [WORD_W-1:0] compare;
		logic [CSEL_W-1:0] csel;
		logic              running_now;
		timer_setting_t    pending[$];
		int                errors;

		function new();
			smoothed    = '0;
			top         = '0;
			compare     = '0;
			csel        = '0;
			running_now = 1'b0;
			errors      = 0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void load_duty(int unsigned duty);
			int unsigned tp;
			tp = top;
			if (duty > DUTY_MAX)
				duty = DUTY_MAX;
			running_now = (duty != 0);
			compare     = WORD_W'((duty * (tp + 1)) >> DUTY_W);
		endfunction

		function void note_request(logic [ACT_W-1:0] act, logic [DUTY_W-1:0] tgt,
				logic [WORD_W-1:0] frq);
			int unsigned d, t, f, divider, quot, duty, tp, cp, clk_hz;
			timer_setting_t s;
			d = smoothed;
			tp = top;
			cp = compare;
			clk_hz = CLOCK_HZ;
			s.divider_used = DIVIDER_NONE;
			case (act)
				ACT_ENABLE: begin
					t = ((d << FILTER_SHIFT) - d + tgt) >> FILTER_SHIFT;
					if (d < tgt)
						t++;
					if (t > DUTY_MAX)
						t = DUTY_MAX;
					load_duty(t);
					smoothed = DUTY_W'(t);
				end
				ACT_DISABLE: begin
					t = ((d << FILTER_SHIFT) - d) >> FILTER_SHIFT;
					load_duty(t);
					smoothed = DUTY_W'(t);
				end
				ACT_SETFREQ: begin
					f = frq;
					if (f < FREQ_MIN)
						f = FREQ_MIN;
					if (f > FREQ_MAX)
						f = FREQ_MAX;
					duty = (tp == 0) ? 0 : (cp << DUTY_W) / tp;
					if (f < FREQ_DIV8_LIMIT) begin
						divider = DIVIDER_EIGHT;
						csel = CSEL_DIV8;
					end else begin
						divider = DIVIDER_ONE;
						csel = CSEL_DIV1;
					end
					quot = clk_hz / (divider * f);
					if (quot == 0)
						top = '0;
					else if (quot - 1 > {WORD_W{1'b1}})
						top = '1;
					else
						top = WORD_W'(quot - 1);
					load_duty(duty);
					s.divider_used = DIVOUT_W'(divider);
				end
				default: return;
			endcase
			s.compare_value   = compare;
			s.period_top      = top;
			s.clock_select    = csel;
			s.running         = running_now;
			s.counter_restart = 1'b1;
			pending.push_back(s);
		endfunction

		task check_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
			if (got !== want)
				report($sformatf("%s got %0d, want %0d", name, got, want));
		endtask

		task check_setting(timer_setting_t got);
			timer_setting_t want;
			if (pending.size() == 0) begin
				report($sformatf("unrequested setting compare %0d top %0d",
					got.compare_value, got.period_top));
				return;
			end
			want = pending.pop_front();
			check_field("compare_value", got.compare_value, want.compare_value);
			check_field("period_top", got.period_top, want.period_top);
			check_field("clock_select", got.clock_select, want.clock_select);
			check_field("divider_used", got.divider_used, want.divider_used);
			check_field("running", got.running, want.running);
			check_field("counter_restart", got.counter_restart, want.counter_restart);
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [ACT_W-1:0]    action = ACT_ENABLE;
	logic [DUTY_W-1:0]   target_duty = '0;
	logic [WORD_W-1:0]   frequency = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [WORD_W-1:0]   compare_value;
	logic [WORD_W-1:0]   period_top;
	logic [CSEL_W-1:0]   clock_select;
	logic [DIVOUT_W-1:0] divider_used;
	logic                running;
	logic                counter_restart;

	timer_setting_tracker book = new();
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int requests_sent  = 0;
	int cycles         = 0;

	pwm_soft_ramp_period_setup_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.target_duty     (target_duty),
		.frequency       (frequency),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.compare_value   (compare_value),
		.period_top      (period_top),
		.clock_select    (clock_select),
		.divider_used    (divider_used),
		.running         (running),
		.counter_restart (counter_restart)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("pwm_soft_ramp_period_setup_unit_tb: errors");
			$finish;
		end
	end

	// take settings and stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_setting('{compare_value, period_top, clock_select, divider_used,
				running, counter_restart});
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send(logic [ACT_W-1:0] act, logic [DUTY_W-1:0] tgt,
			logic [WORD_W-1:0] frq);
		in_valid    <= 1'b1;
		action      <= act;
		target_duty <= tgt;
		frequency   <= frq;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		book.note_request(act, tgt, frq);
		if (act == ACT_ENABLE || act == ACT_DISABLE || act == ACT_SETFREQ)
			requests_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (book.pending.size() != 0);
	endtask

	function automatic logic [DUTY_W-1:0] pick_duty();
		case ($urandom_range(5))
			0: return '0;
			1: return DUTY_MAX;
			default: return DUTY_W'($urandom_range(DUTY_MAX));
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] pick_frequency();
		case ($urandom_range(9))
			0, 1: return WORD_W'($urandom_range(160));
			2: return WORD_W'($urandom_range(110, 135));
			3: begin
				case ($urandom_range(7))
					0: return '0;
					1: return FREQ_MIN - 16'd1;
					2: return FREQ_MIN;
					3: return FREQ_DIV8_LIMIT - 16'd1;
					4: return FREQ_DIV8_LIMIT;
					5: return FREQ_MAX;
					6: return FREQ_MAX + 16'd1;
					default: return '1;
				endcase
			end
			default: return WORD_W'($urandom_range(16'hFFFF));
		endcase
	endfunction

	task automatic run_random(int quota);
		int stop_at;
		logic [DUTY_W-1:0] tgt;
		stop_at = requests_sent + quota;
		while (requests_sent < stop_at) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					// ramp toward one target
					tgt = pick_duty();
					repeat ($urandom_range(4, 40))
						send(ACT_ENABLE, tgt, WORD_W'($urandom));
				end
				3, 4: begin
					repeat ($urandom_range(1, 12))
						send(ACT_DISABLE, DUTY_W'($urandom), WORD_W'($urandom));
				end
				5, 6, 7: send(ACT_SETFREQ, DUTY_W'($urandom), pick_frequency());
				8: send(ACT_W'($urandom_range(ACT_SETFREQ)), pick_duty(), pick_frequency());
				default: send(ACT_UNUSED, DUTY_W'($urandom), WORD_W'($urandom));
			endcase
			if ($urandom_range(29) == 0)
				wait_drained();
		end
	endtask

	initial begin
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero top, frequency clamps and divider boundary, ramps, ignored code
		send(ACT_ENABLE, DUTY_MAX, '0);
		send(ACT_SETFREQ, '0, '0);
		send(ACT_ENABLE, DUTY_MAX, '1);
		send(ACT_ENABLE, DUTY_MAX, '0);
		send(ACT_ENABLE, DUTY_MAX, '1);
		send(ACT_SETFREQ, '1, '1);
		send(ACT_SETFREQ, '0, FREQ_MAX);
		send(ACT_SETFREQ, '0, FREQ_DIV8_LIMIT - 16'd1);
		send(ACT_SETFREQ, '0, FREQ_DIV8_LIMIT);
		send(ACT_SETFREQ, '0, FREQ_MIN - 16'd1);
		send(ACT_SETFREQ, '0, FREQ_MIN);
		send(ACT_UNUSED, DUTY_MAX, 16'd1000);
		send(ACT_SETFREQ, '0, 16'd1000);
		send(ACT_ENABLE, '0, '0);
		send(ACT_DISABLE, '1, '1);
		send(ACT_DISABLE, '0, '0);
		send(ACT_ENABLE, 10'd512, '0);
		send(ACT_ENABLE, 10'd512, '0);
		send(ACT_SETFREQ, '0, 16'd20000);
		send(ACT_DISABLE, '0, '0);
		send(ACT_ENABLE, '0, '0);
		send(ACT_SETFREQ, '0, '1);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random(PHASE_REQUESTS);
		wait_drained();
		send_idle_pct = 50;
		run_random(PHASE_REQUESTS);
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 50;
		run_random(PHASE_REQUESTS);
		wait_drained();
		send_idle_pct = 14;
		recv_stall_pct = 14;
		run_random(PHASE_REQUESTS);

		wait_drained();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (book.errors == 0 && book.pending.size() == 0)
			$display("pwm_soft_ramp_period_setup_unit_tb: clean");
		else
			$display("pwm_soft_ramp_period_setup_unit_tb: errors");
		$finish;
	end

endmodule
